// ===== rtl/pcw_pkg.sv =====
// Shared types and constants of the particle walk step engine.
// No dependencies; imported by pcw_apb_regs and the top level.
`default_nettype none

package pcw_pkg;

  // Memory geometry
  localparam int unsigned NodeW  = 10;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned PartW  = 6;
  localparam int unsigned ClassW = 3;
  localparam int unsigned PotW   = 18;
  localparam int unsigned OwnW   = 32;
  localparam int unsigned DistW  = 8;
  localparam int unsigned RateW  = 17;
  localparam int unsigned CountW = 5;
  localparam int unsigned LabelW = 4;

  localparam int unsigned MaxDegree  = 1 << SlotW;
  localparam int unsigned MaxClasses = 1 << ClassW;
  localparam logic [PotW-1:0] PotMax = '1;

  // Roulette weight and sum widths
  localparam int unsigned WeightW = 21;
  localparam int unsigned SumW    = WeightW + SlotW;

  // Register map (index = paddr / 4)
  localparam logic [2:0] RegGreedy = 3'd0;
  localparam logic [2:0] RegChange = 3'd1;
  localparam logic [2:0] RegRival  = 3'd2;
  localparam logic [2:0] RegLearn  = 3'd3;
  localparam logic [2:0] RegClass  = 3'd4;

  typedef enum logic [2:0] {
    OP_NEIGHBOR = 3'd0,
    OP_NODE     = 3'd1,
    OP_POTENTIAL = 3'd2,
    OP_PARTICLE = 3'd3,
    OP_DISTANCE = 3'd4,
    OP_WEIGHT   = 3'd5,
    OP_MOVE     = 3'd6,
    OP_READ     = 3'd7
  } op_e;

  typedef struct packed {
    logic [RateW-1:0] greedy_probability;
    logic [RateW-1:0] potential_change_rate;
    logic [RateW-1:0] rival_share;
    logic [RateW-1:0] particle_learning_rate;
    logic [3:0]       class_count;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pcw_ram.sv =====
// Single-port synchronous RAM with a registered read.
// Depends on nothing; instanced for each state memory of the engine.
`default_nettype none

module pcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first single port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pcw_apb_regs.sv =====
// APB configuration registers of the walk step engine.
// Depends on pcw_pkg for the register map and the cfg_t bundle.
`default_nettype none

module pcw_apb_regs
  import pcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.greedy_probability     <= RateW'(32768);
      cfg_q.potential_change_rate  <= RateW'(6554);
      cfg_q.rival_share            <= RateW'(6554);
      cfg_q.particle_learning_rate <= RateW'(39322);
      cfg_q.class_count            <= 4'd2;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        RegGreedy: cfg_q.greedy_probability     <= pwdata[RateW-1:0];
        RegChange: cfg_q.potential_change_rate  <= pwdata[RateW-1:0];
        RegRival:  cfg_q.rival_share            <= pwdata[RateW-1:0];
        RegLearn:  cfg_q.particle_learning_rate <= pwdata[RateW-1:0];
        RegClass:  cfg_q.class_count            <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[4:2])
      RegGreedy: prdata = {15'd0, cfg_q.greedy_probability};
      RegChange: prdata = {15'd0, cfg_q.potential_change_rate};
      RegRival:  prdata = {15'd0, cfg_q.rival_share};
      RegLearn:  prdata = {15'd0, cfg_q.particle_learning_rate};
      RegClass:  prdata = {28'd0, cfg_q.class_count};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/particle_competition_walk_step.sv =====
// Top level: sequencer for one particle move over the graph memories.
// Depends on pcw_pkg, pcw_ram and pcw_apb_regs.
//
//   port group | handshake           | payload
//   -----------+---------------------+-------------------------------------------
//   input      | in_valid_i/ready_o  | opcode, node, slot/class, particle, value..
//   output     | out_valid_o/ready_i | chosen node, position, flags, potentials
//   config     | APB psel/penable    | five rate and count registers
//
// A load writes its memory when accepted; a read fetches a potential and an
// ownership word. A greedy move with n neighbors and cc classes fetches n weights,
// walks the roulette, drains rival classes on an unlabeled target and scans the
// classes for the maximum. A random move skips the weight fetch and adds an
// ownership update; every access goes through the one port of each memory.
// After reset a pass over every address zeroes the ownership memory; no transaction
// is taken meanwhile. A result waits in the output register; the sequencer
// holds in its last step only while the previous result is still untaken.
`default_nettype none

module particle_competition_walk_step
  import pcw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [NodeW-1:0]    node_index_i,
  input  wire logic [SlotW-1:0]    slot_or_class_i,
  input  wire logic [PartW-1:0]    particle_index_i,
  input  wire logic [PotW-1:0]     write_value_i,
  input  wire logic [LabelW-1:0]   class_label_i,
  input  wire logic [15:0]         choice_random_i,
  input  wire logic [15:0]         pick_random_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [NodeW-1:0]    chosen_node_o,
  output logic      [NodeW-1:0]    new_position_o,
  output logic                     moved_o,
  output logic                     greedy_used_o,
  output logic      [PotW-1:0]     particle_potential_out_o,
  output logic      [PotW-1:0]     read_potential_o,
  output logic      [OwnW-1:0]     read_ownership_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int unsigned PrW = NodeW + ClassW + PotW;
  localparam int unsigned CpA = ClassW + NodeW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_READ, S_PREC, S_NINFO, S_WADDR, S_WNB, S_WCP, S_WDW,
    S_WACC, S_RMUL, S_RWALK, S_RK, S_SEED, S_DRD, S_DWR, S_ORD, S_OWR,
    S_OWRD, S_OWWR, S_PURD, S_PUMUL, S_PUAPP, S_PDRD, S_PDK, S_MXRD,
    S_MXCMP, S_FIN, S_OUT
  } state_e;

  cfg_t cfg;

  pcw_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // ---------------------------------------------------------------------
  // Memory ports
  logic                    nt_we, ni_we, cp_we, ow_we, pd_we, pr_we, dw_we;
  logic [NodeW+SlotW-1:0]  nt_addr;
  logic [NodeW-1:0]        nt_wdata, nt_rdata;
  logic [NodeW-1:0]        ni_addr;
  logic [CountW+LabelW-1:0] ni_wdata, ni_rdata;
  logic [CpA-1:0]          cp_addr, ow_addr;
  logic [PotW-1:0]         cp_wdata, cp_rdata;
  logic [OwnW-1:0]         ow_wdata, ow_rdata;
  logic [PartW+NodeW-1:0]  pd_addr;
  logic [DistW-1:0]        pd_wdata, pd_rdata;
  logic [PartW-1:0]        pr_addr;
  logic [PrW-1:0]          pr_wdata, pr_rdata;
  logic [DistW-1:0]        dw_addr;
  logic [PotW-1:0]         dw_wdata, dw_rdata;

  pcw_ram #(.Width(NodeW), .Depth(1 << (NodeW + SlotW))) u_nt (
    .clk_i(clk_i), .we_i(nt_we), .addr_i(nt_addr), .wdata_i(nt_wdata), .rdata_o(nt_rdata));
  pcw_ram #(.Width(CountW + LabelW), .Depth(1 << NodeW)) u_ni (
    .clk_i(clk_i), .we_i(ni_we), .addr_i(ni_addr), .wdata_i(ni_wdata), .rdata_o(ni_rdata));
  pcw_ram #(.Width(PotW), .Depth(1 << CpA)) u_cp (
    .clk_i(clk_i), .we_i(cp_we), .addr_i(cp_addr), .wdata_i(cp_wdata), .rdata_o(cp_rdata));
  pcw_ram #(.Width(OwnW), .Depth(1 << CpA)) u_ow (
    .clk_i(clk_i), .we_i(ow_we), .addr_i(ow_addr), .wdata_i(ow_wdata), .rdata_o(ow_rdata));
  pcw_ram #(.Width(DistW), .Depth(1 << (PartW + NodeW))) u_pd (
    .clk_i(clk_i), .we_i(pd_we), .addr_i(pd_addr), .wdata_i(pd_wdata), .rdata_o(pd_rdata));
  pcw_ram #(.Width(PrW), .Depth(1 << PartW)) u_pr (
    .clk_i(clk_i), .we_i(pr_we), .addr_i(pr_addr), .wdata_i(pr_wdata), .rdata_o(pr_rdata));
  pcw_ram #(.Width(PotW), .Depth(1 << DistW)) u_dw (
    .clk_i(clk_i), .we_i(dw_we), .addr_i(dw_addr), .wdata_i(dw_wdata), .rdata_o(dw_rdata));

  // ---------------------------------------------------------------------
  // Sequencer state
  state_e              state_q;
  logic [CpA-1:0]      clr_q;
  logic [PartW-1:0]    p_q;
  logic                greedy_q, rd_ok_q;
  logic [15:0]         pick_q;
  logic [NodeW-1:0]    pos_q, k_q;
  logic [ClassW-1:0]   c_q;
  logic [PotW-1:0]     pp_q, pot_q, share_q, np_q, maxpot_q;
  logic [CountW-1:0]   n_q, i_q;
  logic [3:0]          ci_q;
  logic [SumW-1:0]     sum_q, r_q;
  logic [2*PotW-1:0]   prod_q;
  logic signed [22:0]  gain_q;
  logic [PotW+RateW-1:0] dl_q;
  logic                dec_q;
  logic [DistW-1:0]    dpos_q;
  logic [WeightW-1:0]  pw_q [MaxDegree];

  // staged result
  logic [NodeW-1:0]    st_chosen_q, st_newpos_q;
  logic                st_moved_q;
  logic [PotW-1:0]     st_pp_q, st_rpot_q;
  logic [OwnW-1:0]     st_rown_q;

  // output register
  logic                out_valid_q;
  logic [NodeW-1:0]    o_chosen_q, o_newpos_q;
  logic                o_moved_q, o_greedy_q;
  logic [PotW-1:0]     o_pp_q, o_rpot_q;
  logic [OwnW-1:0]     o_rown_q;

  logic       accept;
  op_e        op;
  logic [3:0] cc_eff;
  logic [WeightW-1:0] cur_w;
  logic [PotW:0]      a_minus;
  logic [PotW+RateW-1:0] share_full, gain_full;
  logic [SumW+15:0]   pick_prod;
  logic [PotW-1:0]    diff;
  logic signed [23:0] own_sum;
  logic [PotW:0]      pp_up;
  logic [OwnW:0]      ow_sum;
  logic               moved;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign op         = op_e'(opcode_i);
  assign cc_eff     = (cfg.class_count > 4'(MaxClasses)) ? 4'(MaxClasses) : cfg.class_count;
  assign cur_w      = greedy_q ? pw_q[i_q[SlotW-1:0]] : WeightW'(1);
  assign a_minus    = {1'b0, cp_rdata} - {1'b0, share_q};
  assign share_full = pp_q * cfg.rival_share;
  assign gain_full  = pp_q * cfg.potential_change_rate;
  assign pick_prod  = pick_q * sum_q;
  assign diff       = (cp_rdata >= pp_q) ? (cp_rdata - pp_q) : (pp_q - cp_rdata);
  assign own_sum    = $signed({6'd0, cp_rdata}) + 24'(gain_q);
  assign pp_up      = {1'b0, pp_q} + {1'b0, dl_q[PotW+15:16]};
  assign ow_sum     = {1'b0, ow_rdata} + {15'd0, pp_q};
  assign moved      = (np_q >= maxpot_q);

  // memory address and write muxing
  always_comb begin
    nt_we = 1'b0; nt_addr = {pos_q, i_q[SlotW-1:0]}; nt_wdata = write_value_i[NodeW-1:0];
    ni_we = 1'b0; ni_addr = node_index_i;
    ni_wdata = {(write_value_i > PotW'(MaxDegree)) ? CountW'(MaxDegree)
                                                   : write_value_i[CountW-1:0],
                class_label_i};
    cp_we = 1'b0; cp_addr = {c_q, k_q}; cp_wdata = write_value_i;
    ow_we = 1'b0; ow_addr = {c_q, k_q}; ow_wdata = '0;
    pd_we = 1'b0; pd_addr = {p_q, k_q}; pd_wdata = write_value_i[DistW-1:0];
    pr_we = 1'b0; pr_addr = p_q;
    pr_wdata = {node_index_i, class_label_i[ClassW-1:0] - 3'd1, write_value_i};
    dw_we = 1'b0; dw_addr = node_index_i[DistW-1:0]; dw_wdata = write_value_i;
    unique case (state_q)
      S_CLR: begin
        ow_we = 1'b1; ow_addr = clr_q;
      end
      S_IDLE: begin
        nt_addr = {node_index_i, slot_or_class_i};
        cp_addr = {slot_or_class_i[ClassW-1:0], node_index_i};
        ow_addr = {slot_or_class_i[ClassW-1:0], node_index_i};
        pd_addr = {particle_index_i, node_index_i};
        pr_addr = particle_index_i;
        if (accept) begin
          unique case (op)
            OP_NEIGHBOR:  nt_we = 1'b1;
            OP_NODE:      ni_we = 1'b1;
            OP_POTENTIAL: cp_we = !slot_or_class_i[SlotW-1];
            OP_PARTICLE:  pr_we = 1'b1;
            OP_DISTANCE:  pd_we = 1'b1;
            OP_WEIGHT:    dw_we = 1'b1;
            default: ;
          endcase
        end
      end
      S_PREC:  ni_addr = pr_rdata[PrW-1:ClassW+PotW];
      S_WNB: begin
        cp_addr = {c_q, nt_rdata};
        pd_addr = {p_q, nt_rdata};
      end
      S_WCP:   dw_addr = pd_rdata;
      S_RK:    ni_addr = nt_rdata;
      S_DRD:   cp_addr = {ci_q[ClassW-1:0], k_q};
      S_DWR: begin
        cp_addr  = {ci_q[ClassW-1:0], k_q};
        cp_we    = 1'b1;
        cp_wdata = a_minus[PotW] ? '0 : a_minus[PotW-1:0];
      end
      S_OWR: begin
        cp_we    = 1'b1;
        cp_wdata = own_sum[23] ? '0 :
                   (own_sum > 24'(PotMax)) ? PotMax : own_sum[PotW-1:0];
      end
      S_OWWR: begin
        ow_we    = 1'b1;
        ow_wdata = ow_sum[OwnW] ? '1 : ow_sum[OwnW-1:0];
      end
      S_PUAPP: pd_addr = {p_q, pos_q};
      S_PDK: begin
        pd_we    = ({1'b0, dpos_q} + 9'd1) < {1'b0, pd_rdata};
        pd_wdata = dpos_q + 8'd1;
      end
      S_MXRD:  cp_addr = {ci_q[ClassW-1:0], k_q};
      S_FIN: begin
        pr_we    = 1'b1;
        pr_wdata = {moved ? k_q : pos_q, c_q, pp_q};
      end
      default: ;
    endcase
  end

  // roulette weights: written once per neighbor, read by the walk
  always_ff @(posedge clk_i) begin
    if (state_q == S_WACC) begin
      pw_q[i_q[SlotW-1:0]] <= prod_q[2*PotW-1:16] + WeightW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        p_q         <= particle_index_i;
        pick_q      <= pick_random_i;
        rd_ok_q     <= !slot_or_class_i[SlotW-1];
        st_chosen_q <= '0;
        st_newpos_q <= '0;
        st_moved_q  <= 1'b0;
        st_pp_q     <= '0;
        st_rpot_q   <= '0;
        st_rown_q   <= '0;
      end
      S_READ: begin
        st_rpot_q <= rd_ok_q ? cp_rdata : '0;
        st_rown_q <= rd_ok_q ? ow_rdata : '0;
      end
      S_PREC: begin
        pos_q <= pr_rdata[PrW-1:ClassW+PotW];
        c_q   <= pr_rdata[ClassW+PotW-1:PotW];
        pp_q  <= pr_rdata[PotW-1:0];
      end
      S_NINFO: begin
        n_q         <= ni_rdata[CountW+LabelW-1:LabelW];
        share_q     <= share_full[PotW+15:16];
        i_q         <= '0;
        sum_q       <= greedy_q ? '0 : SumW'(ni_rdata[CountW+LabelW-1:LabelW]);
        st_chosen_q <= pos_q;
        st_newpos_q <= pos_q;
        st_pp_q     <= pp_q;
      end
      S_WCP:  pot_q  <= cp_rdata;
      S_WDW:  prod_q <= pot_q * dw_rdata;
      S_WACC: begin
        sum_q <= sum_q + SumW'(prod_q[2*PotW-1:16] + WeightW'(1));
        i_q   <= i_q + 5'd1;
      end
      S_RMUL: begin
        r_q <= pick_prod[SumW+15:16];
        i_q <= '0;
      end
      S_RWALK: begin
        if ((i_q + 5'd1) < n_q && SumW'(cur_w) <= r_q) begin
          r_q <= r_q - SumW'(cur_w);
          i_q <= i_q + 5'd1;
        end
      end
      S_RK: begin
        k_q    <= nt_rdata;
        gain_q <= 23'(gain_full[PotW+15:16]);
        ci_q   <= '0;
      end
      S_DRD: begin
        if (ci_q < cc_eff && ci_q[ClassW-1:0] == c_q) begin
          ci_q <= ci_q + 4'd1;
        end
      end
      S_DWR: begin
        if (a_minus[PotW]) begin
          gain_q <= gain_q + 23'($signed(a_minus));
        end
        ci_q <= ci_q + 4'd1;
      end
      S_PUMUL: begin
        np_q  <= cp_rdata;
        dec_q <= cp_rdata < pp_q;
        dl_q  <= diff * cfg.particle_learning_rate;
      end
      S_PUAPP: begin
        if (dec_q) begin
          pp_q <= (dl_q[PotW+15:16] > pp_q) ? '0 : pp_q - dl_q[PotW+15:16];
        end else begin
          pp_q <= pp_up[PotW] ? PotMax : pp_up[PotW-1:0];
        end
      end
      S_PDRD: dpos_q <= pd_rdata;
      S_PDK: begin
        ci_q     <= '0;
        maxpot_q <= '0;
      end
      S_MXCMP: begin
        if (cp_rdata > maxpot_q) begin
          maxpot_q <= cp_rdata;
        end
        ci_q <= ci_q + 4'd1;
      end
      S_FIN: begin
        st_chosen_q <= k_q;
        st_newpos_q <= moved ? k_q : pos_q;
        st_moved_q  <= moved;
        st_pp_q     <= pp_q;
      end
      default: ;
    endcase
  end

  // control FSM and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      greedy_q    <= 1'b0;
      out_valid_q <= 1'b0;
      o_chosen_q  <= '0;
      o_newpos_q  <= '0;
      o_moved_q   <= 1'b0;
      o_greedy_q  <= 1'b0;
      o_pp_q      <= '0;
      o_rpot_q    <= '0;
      o_rown_q    <= '0;
    end else begin
      // result taken; S_OUT reloads the register itself
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CpA'(1);
          if (&clr_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            greedy_q <= (op == OP_MOVE) &&
                        ({1'b0, choice_random_i} < cfg.greedy_probability);
            priority case (op)
              OP_MOVE: state_q <= S_PREC;
              OP_READ: state_q <= S_READ;
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_READ:  state_q <= S_OUT;
        S_PREC:  state_q <= S_NINFO;
        S_NINFO: begin
          priority if (ni_rdata[CountW+LabelW-1:LabelW] == '0) state_q <= S_OUT;
          else if (greedy_q) state_q <= S_WADDR;
          else               state_q <= S_RMUL;
        end
        S_WADDR: state_q <= S_WNB;
        S_WNB:   state_q <= S_WCP;
        S_WCP:   state_q <= S_WDW;
        S_WDW:   state_q <= S_WACC;
        S_WACC:  state_q <= ((i_q + 5'd1) == n_q) ? S_RMUL : S_WADDR;
        S_RMUL:  state_q <= S_RWALK;
        S_RWALK: begin
          if (!((i_q + 5'd1) < n_q && SumW'(cur_w) <= r_q)) state_q <= S_RK;
        end
        S_RK:    state_q <= S_SEED;
        S_SEED: begin
          priority if (ni_rdata[LabelW-1:0] == '0) state_q <= S_DRD;
          else if (greedy_q) state_q <= S_PURD;
          else               state_q <= S_OWRD;
        end
        S_DRD: begin
          priority if (ci_q >= cc_eff) state_q <= S_ORD;
          else if (ci_q[ClassW-1:0] != c_q) state_q <= S_DWR;
          else state_q <= S_DRD;
        end
        S_DWR:   state_q <= S_DRD;
        S_ORD:   state_q <= S_OWR;
        S_OWR:   state_q <= greedy_q ? S_PURD : S_OWRD;
        S_OWRD:  state_q <= S_OWWR;
        S_OWWR:  state_q <= S_PURD;
        S_PURD:  state_q <= S_PUMUL;
        S_PUMUL: state_q <= S_PUAPP;
        S_PUAPP: state_q <= S_PDRD;
        S_PDRD:  state_q <= S_PDK;
        S_PDK:   state_q <= S_MXRD;
        S_MXRD:  state_q <= (ci_q >= cc_eff) ? S_FIN : S_MXCMP;
        S_MXCMP: state_q <= S_MXRD;
        S_FIN:   state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_chosen_q  <= st_chosen_q;
            o_newpos_q  <= st_newpos_q;
            o_moved_q   <= st_moved_q;
            o_greedy_q  <= greedy_q;
            o_pp_q      <= st_pp_q;
            o_rpot_q    <= st_rpot_q;
            o_rown_q    <= st_rown_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o              = out_valid_q;
  assign chosen_node_o            = o_chosen_q;
  assign new_position_o           = o_newpos_q;
  assign moved_o                  = o_moved_q;
  assign greedy_used_o            = o_greedy_q;
  assign particle_potential_out_o = o_pp_q;
  assign read_potential_o         = o_rpot_q;
  assign read_ownership_o         = o_rown_q;

  // ---------------------------------------------------------------------
  // Assertions
  a_clr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_ready_o)
    else $error("transaction accepted during ownership clear");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RWALK) |-> (i_q < n_q))
    else $error("roulette index beyond neighbor count");

  a_drain_not_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWR) |-> (ci_q[ClassW-1:0] != c_q && ci_q < cc_eff))
    else $error("drain wrote own class or unused class");

  a_greedy_no_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ow_we && state_q != S_CLR) |-> !greedy_q)
    else $error("ownership updated on a greedy move");

endmodule

`default_nettype wire
